@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of clk; ASSERT_CLK checks are switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check clocked by clk with reset disable.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check clocked by clk that also holds during reset.
`define ASSERT_CLK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/mjdcal_pkg.sv @@
package mjdcal_pkg;

  // Number of register stages from input to the output register.
  localparam int unsigned NUM_STAGES = 8;

  // Earliest date handled: 1900-03-01. Lower dates are clamped to it.
  localparam logic [15:0] MJD_MIN = 16'd15079;

  // Y' = floor((100*mjd - 1507820) / 36525)
  localparam logic [22:0] YEAR_OFFSET = 23'd1507820;
  localparam logic [15:0] YEAR_DIV    = 16'd36525;
  // floor(2^32 / 36525)
  localparam logic [16:0] YEAR_RECIP  = 17'd117589;

  // M' = floor((10000*(mjd - A) - 149561000) / 306001)
  localparam logic [29:0] MONTH_OFFSET = 30'd149561000;
  localparam logic [22:0] MONTH_DIV    = 23'd306001;
  // floor(2^32 / 306001)
  localparam logic [13:0] MONTH_RECIP  = 14'd14035;

  localparam logic [15:0] DAY_OFFSET = 16'd14956;

  // Decoded time of day, carried alongside the date arithmetic.
  typedef struct packed {
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } hms_t;

  // 10 * high digit + low digit, with nibbles above nine used as they are.
  function automatic logic [7:0] bcd_pair(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // int(30.6001 * m) for the month counter.
  function automatic logic [8:0] month_days(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

endpackage

@@ src/mjd_bcd_time_to_calendar.sv @@
// Converts a Modified Julian Date and a BCD time of day into calendar fields.
// Input channel: in_valid / in_stall carry mjd and utc_bcd. Output channel:
// out_valid / out_stall carry year_since_1900, month_index, day_of_month,
// hours, minutes and seconds. An item moves on a rising edge where valid is
// high and stall is low.
// An accepted item passes through eight stage registers, the last of which
// is the output register. Throughput is one item per cycle while out_stall
// is low. Two stages serve each constant division (reciprocal multiply,
// then a multiply-back correction).
// Each stage loads whenever it is empty or the stage after it moves, so a
// stalled receiver holds the output register steady while the earlier
// stages keep filling their bubbles; in_stall rises only once all eight
// stages hold items.
// Reset (rst, synchronous) empties the pipeline; items in flight are lost.
// Dates before 1900-03-01 convert as 1900-03-01. BCD nibbles above nine are
// used as binary values and are not flagged.
`include "assert_macros.svh"

module mjd_bcd_time_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] mjd,
  input  logic [23:0] utc_bcd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  year_since_1900,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month,
  output logic [7:0]  hours,
  output logic [7:0]  minutes,
  output logic [7:0]  seconds
);

  logic [mjdcal_pkg::NUM_STAGES:1] stage_valid;
  logic [mjdcal_pkg::NUM_STAGES:1] advance;
  mjdcal_pkg::hms_t                tm [1:mjdcal_pkg::NUM_STAGES];

  // Stage payloads.
  logic [15:0] s1_mjd, s2_mjd, s3_mjd, s4_mjd;
  logic [22:0] s1_n1, s2_n1;
  logic [7:0]  s2_q1;
  logic [7:0]  s3_yp, s4_yp, s5_yp, s6_yp, s7_yp;
  logic [15:0] s4_a;
  logic [15:0] s5_diff, s6_diff, s7_diff;
  logic [23:0] s5_n2, s6_n2;
  logic [3:0]  s6_q2;
  logic [3:0]  s7_mp;
  logic [7:0]  out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;

  // Combinational terms between stages.
  logic [15:0] mjd_clamped;
  logic [22:0] n1_calc;
  logic [39:0] prod1;
  logic [22:0] back1;
  logic [22:0] rem1;
  logic [18:0] a_prod;
  logic [15:0] diff_calc;
  logic [29:0] n2_wide;
  logic [37:0] prod2;
  logic [22:0] back2;
  logic [23:0] rem2;
  logic        leap_k;
  logic [8:0]  b_days;

  // A stage loads when it is empty or its item leaves this cycle.
  always_comb begin
    advance[mjdcal_pkg::NUM_STAGES] = !stage_valid[mjdcal_pkg::NUM_STAGES] || !out_stall;
    for (int i = mjdcal_pkg::NUM_STAGES - 1; i >= 1; i--) begin
      advance[i] = !stage_valid[i] || advance[i + 1];
    end
  end

  assign in_stall = !advance[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int i = mjdcal_pkg::NUM_STAGES; i >= 2; i--) begin
        if (advance[i]) begin
          stage_valid[i] <= stage_valid[i - 1];
        end
      end
      if (advance[1]) begin
        stage_valid[1] <= in_valid;
      end
    end
  end

  // Stage 1: clamp, scale the date, decode the time.
  assign mjd_clamped = (mjd < mjdcal_pkg::MJD_MIN) ? mjdcal_pkg::MJD_MIN : mjd;
  assign n1_calc     = 23'(23'(mjd_clamped) * 23'd100) - mjdcal_pkg::YEAR_OFFSET;

  // Stage 2: year quotient estimate, low by at most one.
  assign prod1 = 40'(s1_n1) * 40'(mjdcal_pkg::YEAR_RECIP);

  // Stage 3: correct the estimate from the remainder.
  assign back1 = 23'(23'(s2_q1) * 23'(mjdcal_pkg::YEAR_DIV));
  assign rem1  = s2_n1 - back1;

  // Stage 4: A = int(365.25 * Y').
  assign a_prod = 19'(s3_yp) * 19'd1461;

  // Stage 5: month numerator.
  assign diff_calc = s4_mjd - s4_a;
  assign n2_wide   = 30'(diff_calc) * 30'd10000 - mjdcal_pkg::MONTH_OFFSET;

  // Stage 6: month quotient estimate.
  assign prod2 = 38'(s5_n2) * 38'(mjdcal_pkg::MONTH_RECIP);

  // Stage 7: correction.
  assign back2 = 23'(23'(s6_q2) * mjdcal_pkg::MONTH_DIV);
  assign rem2  = s6_n2 - 24'(back2);

  // Stage 8: January and February belong to the following year.
  assign leap_k = (s7_mp == 4'd14) || (s7_mp == 4'd15);
  assign b_days = mjdcal_pkg::month_days(s7_mp);

  always_ff @(posedge clk) begin
    if (advance[1]) begin
      s1_mjd <= mjd_clamped;
      s1_n1  <= n1_calc;
      tm[1]  <= '{hours:   mjdcal_pkg::bcd_pair(utc_bcd[23:16]),
                  minutes: mjdcal_pkg::bcd_pair(utc_bcd[15:8]),
                  seconds: mjdcal_pkg::bcd_pair(utc_bcd[7:0])};
    end
    if (advance[2]) begin
      s2_mjd <= s1_mjd;
      s2_n1  <= s1_n1;
      s2_q1  <= prod1[39:32];
      tm[2]  <= tm[1];
    end
    if (advance[3]) begin
      s3_mjd <= s2_mjd;
      s3_yp  <= (rem1 >= 23'(mjdcal_pkg::YEAR_DIV)) ? s2_q1 + 8'd1 : s2_q1;
      tm[3]  <= tm[2];
    end
    if (advance[4]) begin
      s4_mjd <= s3_mjd;
      s4_yp  <= s3_yp;
      s4_a   <= a_prod[17:2];
      tm[4]  <= tm[3];
    end
    if (advance[5]) begin
      s5_yp   <= s4_yp;
      s5_diff <= diff_calc;
      s5_n2   <= n2_wide[23:0];
      tm[5]   <= tm[4];
    end
    if (advance[6]) begin
      s6_yp   <= s5_yp;
      s6_diff <= s5_diff;
      s6_n2   <= s5_n2;
      s6_q2   <= prod2[35:32];
      tm[6]   <= tm[5];
    end
    if (advance[7]) begin
      s7_yp   <= s6_yp;
      s7_diff <= s6_diff;
      s7_mp   <= (rem2 >= 24'(mjdcal_pkg::MONTH_DIV)) ? s6_q2 + 4'd1 : s6_q2;
      tm[7]   <= tm[6];
    end
    if (advance[8]) begin
      out_year  <= s7_yp + 8'(leap_k);
      out_month <= leap_k ? s7_mp - 4'd14 : s7_mp - 4'd2;
      out_day   <= 5'(s7_diff - mjdcal_pkg::DAY_OFFSET - 16'(b_days));
      tm[8]     <= tm[7];
    end
  end

  assign out_valid       = stage_valid[mjdcal_pkg::NUM_STAGES];
  assign year_since_1900 = out_year;
  assign month_index     = out_month;
  assign day_of_month    = out_day;
  assign hours           = tm[mjdcal_pkg::NUM_STAGES].hours;
  assign minutes         = tm[mjdcal_pkg::NUM_STAGES].minutes;
  assign seconds         = tm[mjdcal_pkg::NUM_STAGES].seconds;

  `ASSERT_CLK(a_accept_fills_stage1, in_valid && !in_stall |=> stage_valid[1], "accepted item not captured in first stage")
  `ASSERT_CLK_ALWAYS(a_stall_only_when_full, in_stall |-> stage_valid[1], "input stalled while first stage is empty")
  `ASSERT_CLK(a_month_range, out_valid |-> month_index <= 4'd11, "month index out of range")
  `ASSERT_CLK(a_day_nonzero, out_valid |-> day_of_month != 5'd0, "day of month is zero")

endmodule
